[hw/rtl/twist_to_base_control_frame_assert.svh]
// Assertion macros shared by the base-control framer RTL.
// Each use expects i_clk and i_rst_n to be visible in the including module.
`ifndef TWIST_TO_BASE_CONTROL_FRAME_ASSERT_SVH
`define TWIST_TO_BASE_CONTROL_FRAME_ASSERT_SVH

// Plain property checked on every clock edge outside reset.
`define TBCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property that must hold in the same cycle whenever the condition is true.
`define TBCF_ASSERT_IMPL(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

[hw/rtl/tbcf_pkg.sv]
// Shared types and constants for the base-control frame generator.
// No dependencies; every RTL module imports this package.
package tbcf_pkg;

    // Frame layout.
    localparam int          FRAME_LEN   = 10;
    localparam int          FRAME_IDX_W = 4;
    localparam logic [7:0]  SYNC_0      = 8'hAA;
    localparam logic [7:0]  SYNC_1      = 8'h55;
    localparam logic [7:0]  FRAME_TYPE  = 8'h06;

    // Scale factors of the speed and radius arithmetic.
    localparam int DIV_NUM_W   = 27;
    localparam int DIV_DEN_W   = 16;
    localparam int DIV_QUO_W   = 18;
    localparam int DIV_STEPS   = DIV_QUO_W / 2;
    localparam int DIV_CNT_W   = 4;
    localparam logic [DIV_NUM_W-1:0] RAD_SCALE = DIV_NUM_W'(1000);

    // The wheel-speed term is divided by 2000 as a shift by 4 followed by a
    // reciprocal multiply for the division by 125. The reciprocal is rounded up
    // and stays exact over the whole 27-bit numerator range.
    localparam int SPD_PRE_SHIFT = 4;
    localparam int SPD_MUL_W     = DIV_NUM_W - SPD_PRE_SHIFT;
    localparam int SPD_RCP_W     = 24;
    localparam int SPD_PROD_W    = SPD_MUL_W + SPD_RCP_W;
    localparam int SPD_RCP_SHIFT = 30;
    localparam logic [SPD_RCP_W-1:0] SPD_RECIP = 24'd8589935;

    // Saturation bounds of a 16-bit two's complement value.
    localparam logic [15:0] SAT_POS16 = 16'h7FFF;
    localparam logic [15:0] SAT_NEG16 = 16'h8000;

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // Configuration register indexes (byte address / 4).
    localparam logic [2:0] REG_COMMAND_CODE   = 3'd0;
    localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd1;
    localparam logic [2:0] REG_WHEEL_BASE_MM  = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT    = 3'd3;
    localparam logic [2:0] REG_MIN_TURN_SPEED = 3'd4;

    typedef struct packed {
        logic signed [15:0] linear_mm_s;
        logic signed [15:0] angular_mrad_s;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out;

    typedef struct packed {
        logic [7:0]  command_code;
        logic [7:0]  payload_length;
        logic [10:0] wheel_base_mm;
        logic [14:0] speed_limit;
        logic [7:0]  min_turn_speed;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        command_code:   8'd1,
        payload_length: 8'd4,
        wheel_base_mm:  11'd365,
        speed_limit:    15'd2500,
        min_turn_speed: 8'd10
    };

    typedef enum logic [1:0] {
        K_STRAIGHT,
        K_ROTATE,
        K_GENERAL
    } t_kind;

    // One classified command as it waits in the queue.
    typedef struct packed {
        t_kind                 kind;
        logic                  lin_neg;
        logic                  ang_neg;
        logic [15:0]           abs_lin;
        logic [DIV_NUM_W-1:0]  num_rad;
        logic [DIV_DEN_W-1:0]  den_rad;
        logic [DIV_NUM_W-1:0]  num_spd;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef struct packed {
        logic                 done;
        logic                 ovf;
        logic [DIV_QUO_W-1:0] quo;
    } t_div_out;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_back_state;

endpackage

[hw/rtl/twist_to_base_control_frame.sv]
// A command passes through the queue and the radius divider before its frame is loaded
// into the output register; the checksum byte is the last byte of the frame.
// Throughput is set by the one-byte-per-cycle frame output when the sink does not stall;
// the 9-step radius divider for the next command overlaps the previous frame's bytes.
// A two-entry queue keeps input transactions flowing while a frame drains.
// Reset (synchronous, active low) empties the queue and output, and loads defaults.
module twist_to_base_control_frame (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tbcf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tbcf_pkg::t_out o_out_data
);
    import tbcf_pkg::*;

    t_cfg         r_cfg;
    logic         cfg_wr;
    logic [2:0]   reg_idx;

    logic         push;
    logic         pop;
    t_cmd         front_cmd;
    t_cmd         head_cmd;
    t_fifo_status fifo_st;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COMMAND_CODE:   r_cfg.command_code   <= pwdata[7:0];
                REG_PAYLOAD_LENGTH: r_cfg.payload_length <= pwdata[7:0];
                REG_WHEEL_BASE_MM:  r_cfg.wheel_base_mm  <= pwdata[10:0];
                REG_SPEED_LIMIT:    r_cfg.speed_limit    <= pwdata[14:0];
                REG_MIN_TURN_SPEED: r_cfg.min_turn_speed <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COMMAND_CODE:   prdata = {24'd0, r_cfg.command_code};
            REG_PAYLOAD_LENGTH: prdata = {24'd0, r_cfg.payload_length};
            REG_WHEEL_BASE_MM:  prdata = {21'd0, r_cfg.wheel_base_mm};
            REG_SPEED_LIMIT:    prdata = {17'd0, r_cfg.speed_limit};
            REG_MIN_TURN_SPEED: prdata = {24'd0, r_cfg.min_turn_speed};
            default:            prdata = '0;
        endcase
    end

    tbcf_front u_front (
        .i_in_valid      (i_in_valid),
        .i_in_data       (i_in_data),
        .i_wheel_base_mm (r_cfg.wheel_base_mm),
        .i_fifo          (fifo_st),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    tbcf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_cmd),
        .i_pop    (pop),
        .o_data   (head_cmd),
        .o_status (fifo_st)
    );

    tbcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_fifo      (fifo_st),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/tbcf_div.sv]
// Iterative restoring divider, two quotient bits per cycle.
// Depends on tbcf_pkg and the shared assertion header.
`include "twist_to_base_control_frame_assert.svh"

module tbcf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tbcf_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [tbcf_pkg::DIV_DEN_W-1:0] i_den,
    output tbcf_pkg::t_div_out             o_res
);
    import tbcf_pkg::*;

    localparam int DIV_LAT = DIV_STEPS + 1;

    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_QUO_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic                 r_ovf;

    logic [DIV_DEN_W:0]   d_ext;
    logic [DIV_DEN_W:0]   t1;
    logic [DIV_DEN_W:0]   t2;
    logic                 ge1;
    logic                 ge2;
    logic [DIV_DEN_W-1:0] rem1;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_QUO_W-1:0] quo1;
    logic [DIV_QUO_W-1:0] n_quo;
    logic [DIV_DEN_W-1:0] num_top;

    // The numerator bits above the quotient seed the remainder; if they already
    // reach the divisor the quotient does not fit and the overflow flag is set.
    assign num_top = DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_QUO_W]);

    always_comb begin
        d_ext = {1'b0, r_den};
        t1    = {r_rem, r_quo[DIV_QUO_W-1]};
        ge1   = (t1 >= d_ext);
        rem1  = ge1 ? DIV_DEN_W'(t1 - d_ext) : t1[DIV_DEN_W-1:0];
        quo1  = {r_quo[DIV_QUO_W-2:0], ge1};
        t2    = {rem1, quo1[DIV_QUO_W-1]};
        ge2   = (t2 >= d_ext);
        n_rem = ge2 ? DIV_DEN_W'(t2 - d_ext) : t2[DIV_DEN_W-1:0];
        n_quo = {quo1[DIV_QUO_W-2:0], ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= num_top;
            r_quo <= i_num[DIV_QUO_W-1:0];
            r_ovf <= (num_top >= i_den);
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quo  = r_quo;

    `TBCF_ASSERT(a_div_latency, i_start |-> ##DIV_LAT r_done, "divider finished late")
    `TBCF_ASSERT_IMPL(a_div_no_restart, r_cnt != '0, !i_start, "divider restarted while busy")

endmodule

[hw/rtl/tbcf_fifo.sv]
// Short command queue between the classifying front and the framing back.
// Depends on tbcf_pkg and the shared assertion header.
`include "twist_to_base_control_frame_assert.svh"

module tbcf_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  tbcf_pkg::t_cmd         i_data,
    input  logic                   i_pop,
    output tbcf_pkg::t_cmd         o_data,
    output tbcf_pkg::t_fifo_status o_status
);
    import tbcf_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

    `TBCF_ASSERT_IMPL(a_fifo_no_overrun, r_count == FIFO_CNT_W'(FIFO_DEPTH), !i_push,
                      "push into a full command queue")
    `TBCF_ASSERT_IMPL(a_fifo_no_underrun, r_count == '0, !i_pop,
                      "pop from an empty command queue")

endmodule

[hw/rtl/tbcf_front.sv]
// Input side: accepts velocity commands, classifies them and prepares the
// divider operands for the back end. Depends on tbcf_pkg.
module tbcf_front (
    input  logic                   i_in_valid,
    input  tbcf_pkg::t_in          i_in_data,
    input  logic [10:0]            i_wheel_base_mm,
    input  tbcf_pkg::t_fifo_status i_fifo,
    output logic                   o_in_stall,
    output logic                   o_push,
    output tbcf_pkg::t_cmd         o_cmd
);
    import tbcf_pkg::*;

    logic [15:0]          lin_u;
    logic [15:0]          ang_u;
    logic                 lin_neg;
    logic                 ang_neg;
    logic [15:0]          abs_lin;
    logic [15:0]          abs_ang;
    logic [DIV_NUM_W-1:0] lin_scaled;
    logic [DIV_NUM_W-1:0] wb_ang;

    assign o_in_stall = i_fifo.full;
    assign o_push     = i_in_valid && !i_fifo.full;

    always_comb begin
        lin_u      = i_in_data.linear_mm_s;
        ang_u      = i_in_data.angular_mrad_s;
        lin_neg    = lin_u[15];
        ang_neg    = ang_u[15];
        abs_lin    = lin_neg ? (~lin_u + 16'd1) : lin_u;
        abs_ang    = ang_neg ? (~ang_u + 16'd1) : ang_u;
        lin_scaled = DIV_NUM_W'(abs_lin) * RAD_SCALE;
        wb_ang     = DIV_NUM_W'(i_wheel_base_mm) * DIV_NUM_W'(abs_ang);

        o_cmd.lin_neg = lin_neg;
        o_cmd.ang_neg = ang_neg;
        o_cmd.abs_lin = abs_lin;
        o_cmd.num_rad = lin_scaled;
        o_cmd.den_rad = abs_ang;
        o_cmd.num_spd = wb_ang;

        // A tiny forward speed against a large yaw rate is sent as a turn in place.
        if (abs_ang == '0) begin
            o_cmd.kind = K_STRAIGHT;
        end else if (abs_lin == '0 || lin_scaled <= DIV_NUM_W'(abs_ang)) begin
            o_cmd.kind = K_ROTATE;
        end else begin
            o_cmd.kind = K_GENERAL;
        end
    end

endmodule

[hw/rtl/tbcf_back.sv]
// Back end: runs the radius and wheel-speed divisions, applies saturation and
// limits, and serializes the ten-byte frame. Depends on tbcf_pkg and tbcf_div.
`include "twist_to_base_control_frame_assert.svh"

module tbcf_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tbcf_pkg::t_cfg         i_cfg,
    input  tbcf_pkg::t_cmd         i_cmd,
    input  tbcf_pkg::t_fifo_status i_fifo,
    input  logic                   i_out_stall,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output tbcf_pkg::t_out         o_out_data
);
    import tbcf_pkg::*;

    localparam logic [FRAME_IDX_W-1:0] LAST_IDX = FRAME_IDX_W'(FRAME_LEN - 1);

    t_back_state            r_state;
    t_back_state            n_state;
    t_cmd                   r_cmd;
    logic [7:0]             r_frame [FRAME_LEN];
    logic [7:0]             n_frame [FRAME_LEN];
    logic                   r_valid;
    logic [FRAME_IDX_W-1:0] r_idx;

    t_div_out               div_rad;
    logic [SPD_PROD_W-1:0]  spd_prod;
    logic [DIV_QUO_W-1:0]   r_spd_quo;

    logic                   take;
    logic                   ser_free;
    logic                   handoff;

    logic [15:0]            radius;
    logic [15:0]            speed;
    logic [DIV_QUO_W-1:0]   mag;
    logic                   spd_neg;
    logic                   rad_neg;
    logic [15:0]            sat_mag;
    logic [15:0]            lim16;
    logic [15:0]            lim_mag;
    logic [15:0]            mn16;
    logic                   lift;
    logic [7:0]             len;
    logic [7:0]             csum;

    tbcf_div u_div_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop),
        .i_num   (i_cmd.num_rad),
        .i_den   (i_cmd.den_rad),
        .o_res   (div_rad)
    );

    // The taken command is registered in r_cmd and the wheel-speed quotient from it
    // in r_spd_quo, so the quotient settles long before the radius divider finishes.
    assign spd_prod = SPD_PROD_W'(r_cmd.num_spd[DIV_NUM_W-1:SPD_PRE_SHIFT])
                    * SPD_PROD_W'(SPD_RECIP);

    // Controller outputs.
    always_comb begin
        take     = r_valid && !i_out_stall;
        ser_free = !r_valid || (take && r_idx == LAST_IDX);
        handoff  = (r_state == S_BUSY) && div_rad.done && ser_free;
        o_pop    = !i_fifo.empty && ((r_state == S_IDLE) || handoff);
    end

    // Controller next state.
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                n_state = o_pop ? S_BUSY : S_IDLE;
            end
            S_BUSY: begin
                n_state = (handoff && !o_pop) ? S_IDLE : S_BUSY;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Speed and radius from the division results.
    always_comb begin
        rad_neg = r_cmd.lin_neg ^ r_cmd.ang_neg;
        unique case (r_cmd.kind)
            K_ROTATE: begin
                radius  = 16'd1;
                mag     = r_spd_quo;
                spd_neg = r_cmd.ang_neg;
            end
            K_GENERAL: begin
                if (rad_neg) begin
                    radius = (div_rad.ovf || div_rad.quo > DIV_QUO_W'(SAT_NEG16))
                           ? SAT_NEG16 : (~div_rad.quo[15:0] + 16'd1);
                end else begin
                    radius = (div_rad.ovf || div_rad.quo > DIV_QUO_W'(SAT_POS16))
                           ? SAT_POS16 : div_rad.quo[15:0];
                end
                mag     = DIV_QUO_W'(r_cmd.abs_lin) + r_spd_quo;
                spd_neg = r_cmd.lin_neg;
            end
            default: begin
                radius  = '0;
                mag     = DIV_QUO_W'(r_cmd.abs_lin);
                spd_neg = r_cmd.lin_neg;
            end
        endcase

        if (spd_neg) begin
            sat_mag = (mag > DIV_QUO_W'(SAT_NEG16)) ? SAT_NEG16 : mag[15:0];
        end else begin
            sat_mag = (mag > DIV_QUO_W'(SAT_POS16)) ? SAT_POS16 : mag[15:0];
        end
        lim16   = {1'b0, i_cfg.speed_limit};
        lim_mag = (sat_mag > lim16) ? lim16 : sat_mag;
        mn16    = {8'd0, i_cfg.min_turn_speed};

        // A turn in place never goes slower than the minimum; zero turns backward.
        lift = (radius == 16'd1) && (lim_mag < mn16);
        if (lift) begin
            speed = (spd_neg || lim_mag == '0) ? (~mn16 + 16'd1) : mn16;
        end else begin
            speed = spd_neg ? (~lim_mag + 16'd1) : lim_mag;
        end
    end

    // Frame assembly. The checksum span shrinks with a short payload length.
    always_comb begin
        len  = i_cfg.payload_length;
        csum = FRAME_TYPE ^ i_cfg.command_code ^ len;
        if (len >= 8'd1) begin
            csum = csum ^ speed[7:0];
        end
        if (len >= 8'd2) begin
            csum = csum ^ speed[15:8];
        end
        if (len >= 8'd3) begin
            csum = csum ^ radius[7:0];
        end
        if (len >= 8'd4) begin
            csum = csum ^ radius[15:8];
        end
        n_frame[0] = SYNC_0;
        n_frame[1] = SYNC_1;
        n_frame[2] = FRAME_TYPE;
        n_frame[3] = i_cfg.command_code;
        n_frame[4] = len;
        n_frame[5] = speed[7:0];
        n_frame[6] = speed[15:8];
        n_frame[7] = radius[7:0];
        n_frame[8] = radius[15:8];
        n_frame[9] = csum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (handoff) begin
                r_valid <= 1'b1;
                r_idx   <= '0;
            end else if (take) begin
                if (r_idx == LAST_IDX) begin
                    r_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_spd_quo <= DIV_QUO_W'(spd_prod >> SPD_RCP_SHIFT);
        if (handoff) begin
            r_frame <= n_frame;
        end
    end

    assign o_out_valid          = r_valid;
    assign o_out_data.frame_byte = r_frame[r_idx];
    assign o_out_data.last_byte  = (r_idx == LAST_IDX);

    `TBCF_ASSERT(a_back_out_hold, r_valid && i_out_stall |=> r_valid && $stable(r_idx),
                 "stalled frame byte changed")
    `TBCF_ASSERT_IMPL(a_back_idx_range, r_valid, r_idx <= LAST_IDX,
                      "frame byte index past the checksum byte")

endmodule
